[hdl/wpf_pkg.sv]
// Package for the waypoint path follower: field widths and item kinds.
// Depends on nothing; used by hdl/waypoint_path_follower.sv.
package wpf_pkg;
  localparam int CoordW = 24;
  localparam int SpeedW = 16;
  localparam int ElapsedW = 10;
  localparam int BudgetW = SpeedW + ElapsedW;   // 26
  localparam int DeltaW = CoordW + 1;           // 25, signed difference
  localparam int MagW = CoordW + 1;             // magnitude of a difference, unsigned
  // Sum of two squares, padded to an even width so the root takes bit pairs from bit 0.
  localparam int SqW = 2 * MagW + 2;            // 52
  localparam int RootW = (SqW + 1) / 2;         // 26
  localparam int ProdW = MagW + BudgetW;        // 51, |d| * budget
  localparam int CountW = 5;

  localparam logic [1:0] KindAdd = 2'd0;
  localparam logic [1:0] KindTick = 2'd1;
  localparam logic [1:0] KindSet = 2'd2;

  typedef logic signed [CoordW-1:0] coord_t;
endpackage

[hdl/waypoint_path_follower.sv]
// Waypoint path follower: position register, waypoint queue and a tick sequencer with one
// shared multiplier, a bit-serial square root and a bit-serial divider. Uses wpf_pkg.
// Add, set position and unknown kinds go from accept straight to the result beat. A tick
// computes its budget, then for each waypoint reached reads it, forms the difference,
// squares both magnitudes, takes the root, compares and checks again; when it stops short
// at a waypoint, it multiplies each magnitude by the budget left and divides by the root.
// One item is in work at a time; the input stalls until the result beat is taken.
// Reset (rst, synchronous) clears the position, the queue pointers and speed; the
// waypoint memory is not cleared.
module waypoint_path_follower #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] kind,
  input  logic signed [wpf_pkg::CoordW-1:0] coord_x,
  input  logic signed [wpf_pkg::CoordW-1:0] coord_y,
  input  logic [wpf_pkg::ElapsedW-1:0] elapsed_ms,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [wpf_pkg::CoordW-1:0] pos_x,
  output logic signed [wpf_pkg::CoordW-1:0] pos_y,
  output logic [wpf_pkg::CountW-1:0] pending,
  output logic [wpf_pkg::CountW-1:0] passed,
  output logic dropped,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [wpf_pkg::SpeedW-1:0] cfg_data
);
  localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int BW = wpf_pkg::BudgetW;
  localparam int MW = wpf_pkg::MagW;
  localparam int SW = wpf_pkg::SqW;
  localparam int RW = wpf_pkg::RootW;
  localparam int PW = wpf_pkg::ProdW;
  localparam int CW = wpf_pkg::CoordW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BUDG  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_READ  = 4'd3;
  localparam logic [3:0] S_DIFF  = 4'd4;
  localparam logic [3:0] S_MULX  = 4'd5;
  localparam logic [3:0] S_MULY  = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_PMX   = 4'd9;
  localparam logic [3:0] S_DIVX  = 4'd10;
  localparam logic [3:0] S_PMY   = 4'd11;
  localparam logic [3:0] S_DIVY  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state;
  logic [wpf_pkg::SpeedW-1:0] speed;
  wpf_pkg::coord_t cur_x, cur_y;
  logic [IdxW-1:0] head_index;
  logic [CntW-1:0] queued_count;
  logic [2*CW-1:0] wp_mem [QUEUE_DEPTH];
  logic [2*CW-1:0] rd_data;
  logic [1:0] k_kind;
  logic [wpf_pkg::ElapsedW-1:0] k_el;
  logic [BW-1:0] budget;
  logic [CntW-1:0] pass_cnt;
  logic drop_flag;
  logic signed [wpf_pkg::DeltaW-1:0] dx, dy;
  logic [MW-1:0] ax, ay;
  logic [SW-1:0] sq, rem_sq, mul_p;
  logic [RW-1:0] root;
  logic [5:0] cnt;
  logic [PW-1:0] dvd;
  logic [RW:0] drem;
  logic [PW-1:0] quo;
  logic [MW-1:0] mul_a;
  logic [MW-1:0] mul_b;

  logic in_acc, out_acc;
  logic [IdxW-1:0] tail_slot;
  logic [IdxW:0] tail_sum;

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign cfg_ready = (state == S_IDLE) && !out_valid;

  // Shared multiplier, one product per cycle with registered output.
  always_comb begin
    mul_a = ax;
    mul_b = ax;
    case (state)
      S_MULX:  begin mul_a = ax; mul_b = ax; end
      S_MULY:  begin mul_a = ay; mul_b = ay; end
      S_PMX:   begin mul_a = ax; mul_b = MW'(budget); end
      S_PMY:   begin mul_a = ay; mul_b = MW'(budget); end
      default: begin mul_a = ax; mul_b = ax; end
    endcase
  end

  assign tail_sum = {1'b0, head_index} + (IdxW+1)'(queued_count);
  assign tail_slot = (tail_sum >= (IdxW+1)'(QUEUE_DEPTH)) ?
                     IdxW'(tail_sum - (IdxW+1)'(QUEUE_DEPTH)) : IdxW'(tail_sum);

  always_ff @(posedge clk) begin
    if (in_acc && kind == wpf_pkg::KindAdd && queued_count < CntW'(QUEUE_DEPTH)) begin
      wp_mem[tail_slot] <= {coord_x, coord_y};
    end
    rd_data <= wp_mem[head_index];
  end

  // Square root step: one result bit per cycle (restoring).
  logic [RW+1:0] trial;
  logic [RW+1:0] rem_hi;
  assign rem_hi = {rem_sq[RW-1:0], sq[SW-1 -: 2]};
  assign trial = {root, 2'b01};

  // Divider step: one quotient bit per cycle.
  logic [RW:0] dshift;
  assign dshift = {drem[RW-1:0], dvd[PW-1]};

  logic signed [CW:0] move;
  assign move = $signed({1'b0, quo[CW-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      speed <= '0;
      cur_x <= '0;
      cur_y <= '0;
      head_index <= '0;
      queued_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_acc) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) speed <= cfg_data;
      mul_p <= SW'(mul_a * mul_b);
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            k_kind <= kind;
            k_el <= elapsed_ms;
            pass_cnt <= '0;
            drop_flag <= 1'b0;
            state <= (kind == wpf_pkg::KindTick) ? S_BUDG : S_OUT;
            if (kind == wpf_pkg::KindAdd) begin
              if (queued_count >= CntW'(QUEUE_DEPTH)) drop_flag <= 1'b1;
              else queued_count <= queued_count + 1'b1;
            end else if (kind == wpf_pkg::KindSet) begin
              cur_x <= coord_x;
              cur_y <= coord_y;
            end
          end
        end
        S_BUDG: begin
          budget <= BW'(speed * k_el);
          state <= S_CHECK;
        end
        S_CHECK: state <= (budget != '0 && queued_count != '0) ? S_READ : S_OUT;
        S_READ: state <= S_DIFF;   // memory read data lands this cycle
        S_DIFF: begin
          dx <= $signed({rd_data[2*CW-1], rd_data[2*CW-1:CW]}) -
                $signed({cur_x[CW-1], cur_x});
          dy <= $signed({rd_data[CW-1], rd_data[CW-1:0]}) -
                $signed({cur_y[CW-1], cur_y});
          state <= S_MULX;
          cnt <= '0;
        end
        S_MULX: begin
          // Magnitudes are registered before the multiplier sees them; this state waits for the product.
          ax <= dx[CW] ? MW'(-dx) : MW'(dx);
          ay <= dy[CW] ? MW'(-dy) : MW'(dy);
          cnt <= cnt + 1'b1;
          if (cnt == 6'd1) state <= S_MULY;
        end
        S_MULY: begin
          sq <= mul_p;     // ax*ax
          cnt <= cnt + 1'b1;
          if (cnt == 6'd3) begin
            sq <= sq + mul_p;   // add ay*ay
            rem_sq <= '0;
            root <= '0;
            cnt <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (rem_hi >= trial) begin
            rem_sq <= SW'(rem_hi - trial);
            root <= {root[RW-2:0], 1'b1};
          end else begin
            rem_sq <= SW'(rem_hi);
            root <= {root[RW-2:0], 1'b0};
          end
          sq <= {sq[SW-3:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == 6'(RW-1)) state <= S_CMP;
        end
        S_CMP: begin
          cnt <= '0;
          if (BW'(root) <= budget) begin
            budget <= budget - BW'(root);
            cur_x <= rd_data[2*CW-1:CW];
            cur_y <= rd_data[CW-1:0];
            head_index <= (head_index == IdxW'(QUEUE_DEPTH-1)) ? '0 : head_index + 1'b1;
            queued_count <= queued_count - 1'b1;
            pass_cnt <= pass_cnt + 1'b1;
            state <= S_CHECK;
          end else begin
            state <= S_PMX;
          end
        end
        S_PMX, S_PMY: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'd1) begin
            dvd <= PW'(mul_p);
            drem <= '0;
            quo <= '0;
            cnt <= '0;
            state <= (state == S_PMX) ? S_DIVX : S_DIVY;
          end
        end
        S_DIVX, S_DIVY: begin
          if (dshift >= {1'b0, root}) begin
            drem <= dshift - {1'b0, root};
            quo <= {quo[PW-2:0], 1'b1};
          end else begin
            drem <= dshift;
            quo <= {quo[PW-2:0], 1'b0};
          end
          dvd <= {dvd[PW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == 6'(PW-1)) begin
            cnt <= '0;
            if (state == S_DIVX) state <= S_PMY;
            else state <= S_OUT;
          end
        end
        S_OUT: begin
          if (k_kind == wpf_pkg::KindTick && budget != '0 && queued_count != '0) begin
            budget <= '0;
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // Apply a finished quotient to its axis; quotient is below |d| so it fits.
      if (state == S_PMY && cnt == 6'd0) begin
        cur_x <= dx[CW] ? CW'(cur_x - move) : CW'(cur_x + move);
      end
      if (state == S_OUT && k_kind == wpf_pkg::KindTick && budget != '0 &&
          queued_count != '0) begin
        cur_y <= dy[CW] ? CW'(cur_y - move) : CW'(cur_y + move);
      end
    end
  end

  assign pos_x = cur_x;
  assign pos_y = cur_y;
  assign pending = wpf_pkg::CountW'(queued_count);
  assign passed = wpf_pkg::CountW'(pass_cnt);
  assign dropped = drop_flag;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    queued_count <= CntW'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_done_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> out_valid) else $error("result beat missing");
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PMX) |-> (BW'(root) > budget)) else $error("partial move with reachable point");
endmodule
